[hw/rtl/cc20_pkg.sv]
package cc20_pkg;

  localparam int unsigned QR_COUNT = 80;
  localparam int unsigned RND_W = $clog2(QR_COUNT);
  localparam logic [31:0] ROT_PACK = 32'h19181410;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646E;
  localparam logic [31:0] SIGMA_2 = 32'h79622D32;
  localparam logic [31:0] SIGMA_3 = 32'h6B206574;

  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_0      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_1      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_2      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_3      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_IETF_MODE  = 3'd6;

  localparam int unsigned CFG_W = 64;
  localparam int unsigned BYTES_PER_ITEM = 8;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned TDATA_W = 72;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_words_t;

  function automatic logic [31:0] rotr32(logic [31:0] v, logic [4:0] n);
    return (v >> n) | (v << (6'd32 - {1'b0, n}));
  endfunction

endpackage

[hw/rtl/cc20_qr.sv]
module cc20_qr (
  input  cc20_pkg::qr_words_t words_in,
  output cc20_pkg::qr_words_t words_out
);
  import cc20_pkg::*;

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;

  always_comb begin
    a1 = words_in.a + words_in.b;
    d1 = rotr32(words_in.d ^ a1, ROT_PACK[4:0]);
    c1 = words_in.c + d1;
    b1 = rotr32(words_in.b ^ c1, ROT_PACK[12:8]);
    a2 = a1 + b1;
    d2 = rotr32(d1 ^ a2, ROT_PACK[20:16]);
    c2 = c1 + d2;
    b2 = rotr32(b1 ^ c2, ROT_PACK[28:24]);
    words_out.a = a2;
    words_out.b = b2;
    words_out.c = c2;
    words_out.d = d2;
  end

endmodule

[hw/rtl/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher, encrypting or decrypting up to eight bytes per
// transaction. Key, nonce and counter layout (original or IETF) are set
// through the write port; any write to indices 0 to 6 restarts the counter
// and the byte position. Bytes are handled one per cycle, except while a
// keystream block is made. When the byte position is at the start of a
// block, a new keystream block is made first: the words are loaded, the
// single shared quarter-round unit runs 80 quarter-rounds and then the
// final add is done. This work falls on the item that crosses the block
// boundary. A result that waits on the output holds the block in its EMIT
// state until it is taken. The output register lets a new item be taken
// while a result still waits.
module chacha20_stream_cipher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cc20_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [cc20_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // data_in [63:0], byte_count [67:64], zero fill [71:68]
  input  logic [cc20_pkg::TDATA_W-1:0]        s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // data_out [63:0], valid_bytes [67:64], zero fill [71:68]
  output logic [cc20_pkg::TDATA_W-1:0]        m_tdata,
  output logic                                m_tlast
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {IDLE, BYTE, ROUND, FINISH, EMIT} state_t;

  state_t state;

  logic [63:0] key [4];
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic        ietf;
  logic [63:0] counter;
  logic [5:0]  pos;

  logic [31:0] ws [4][4];
  logic [31:0] ws_next [4][4];
  logic [31:0] tmp [4][4];
  logic [31:0] ks [16];
  logic [31:0] inw [16];
  logic [RND_W-1:0] rnd;
  logic        fresh;

  logic [63:0] data;
  logic [63:0] res;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic        last;

  logic [CNT_W-1:0] cnt_in;
  logic        diag;
  logic [1:0]  tb, tc, td;
  qr_words_t   qr_in, qr_out;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  logic [7:0]  db;
  logic        emit_go;

  assign s_tready = (state == IDLE);
  assign cnt_in = (s_tdata[67:64] > CNT_W'(BYTES_PER_ITEM)) ?
                  CNT_W'(BYTES_PER_ITEM) : s_tdata[67:64];
  assign emit_go = (state == EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    inw[0] = SIGMA_0;
    inw[1] = SIGMA_1;
    inw[2] = SIGMA_2;
    inw[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      inw[4 + 2 * i] = key[i][31:0];
      inw[5 + 2 * i] = key[i][63:32];
    end
    inw[12] = counter[31:0];
    if (ietf) begin
      inw[13] = nonce_low[31:0];
      inw[14] = nonce_low[63:32];
      inw[15] = nonce_high;
    end else begin
      inw[13] = counter[63:32];
      inw[14] = nonce_low[31:0];
      inw[15] = nonce_low[63:32];
    end
  end

  // column rounds tap position 0 of every row, diagonal rounds tap the
  // row index; the rows rotate by one word after each quarter-round
  always_comb begin
    diag = rnd[2];
    tb = diag ? 2'd1 : 2'd0;
    tc = diag ? 2'd2 : 2'd0;
    td = diag ? 2'd3 : 2'd0;
    qr_in.a = ws[0][0];
    qr_in.b = ws[1][tb];
    qr_in.c = ws[2][tc];
    qr_in.d = ws[3][td];
    tmp = ws;
    tmp[0][0]  = qr_out.a;
    tmp[1][tb] = qr_out.b;
    tmp[2][tc] = qr_out.c;
    tmp[3][td] = qr_out.d;
    for (int r = 0; r < 4; r++) begin
      for (int p = 0; p < 4; p++) begin
        ws_next[r][p] = tmp[r][(p + 1) % 4];
      end
    end
  end

  cc20_qr u_qr (
    .words_in  (qr_in),
    .words_out (qr_out)
  );

  always_comb begin
    ks_word = ks[pos[5:2]];
    ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];
    db = data[{idx[2:0], 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      for (int i = 0; i < 4; i++) key[i] <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
      ietf     <= 1'b0;
      counter  <= '0;
      pos      <= '0;
      rnd      <= '0;
      fresh    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_0:      key[0] <= cfg_data;
          REG_KEY_1:      key[1] <= cfg_data;
          REG_KEY_2:      key[2] <= cfg_data;
          REG_KEY_3:      key[3] <= cfg_data;
          REG_NONCE_LOW:  nonce_low <= cfg_data;
          REG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
          REG_IETF_MODE:  ietf <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= REG_IETF_MODE) begin
          pos <= '0;
          if (cfg_index == REG_IETF_MODE) begin
            counter <= {63'd0, cfg_data[0]};
          end else begin
            counter <= {63'd0, ietf};
          end
        end
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            data  <= s_tdata[63:0];
            cnt   <= cnt_in;
            last  <= s_tlast;
            idx   <= '0;
            res   <= '0;
            fresh <= 1'b0;
            state <= (cnt_in == '0) ? EMIT : BYTE;
          end
        end
        BYTE: begin
          if (pos == '0 && !fresh) begin
            for (int r = 0; r < 4; r++) begin
              for (int p = 0; p < 4; p++) begin
                ws[r][p] <= inw[4 * r + p];
              end
            end
            rnd   <= '0;
            state <= ROUND;
          end else begin
            res[{idx[2:0], 3'b000} +: 8] <= db ^ ks_byte;
            pos   <= pos + 6'd1;
            fresh <= 1'b0;
            idx   <= idx + 1'b1;
            if (idx + 1'b1 == cnt) begin
              state <= EMIT;
            end
          end
        end
        ROUND: begin
          ws  <= ws_next;
          rnd <= rnd + 1'b1;
          if (rnd == RND_W'(QR_COUNT - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          for (int r = 0; r < 4; r++) begin
            for (int p = 0; p < 4; p++) begin
              ks[4 * r + p] <= ws[r][p] + inw[4 * r + p];
            end
          end
          if (ietf) begin
            counter <= {32'd0, counter[31:0] + 32'd1};
          end else begin
            counter <= counter + 64'd1;
          end
          fresh <= 1'b1;
          state <= BYTE;
        end
        EMIT: begin
          if (emit_go) begin
            m_tdata  <= {4'd0, cnt, res};
            m_tlast  <= last;
            if (last) begin
              pos <= '0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/cc20_checker.sv]
module cc20_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [cc20_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tlast
);
  import cc20_pkg::*;

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // one item at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // reported byte count never exceeds the item width and the fill bits are zero
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[67:64] <= CNT_W'(BYTES_PER_ITEM) && m_tdata[71:68] == 4'd0)
    else $error("bad valid byte count");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
